// File: design/chtd_pkg.sv
// Shared types, constants and result records for the canonical Huffman table decoder.
`default_nettype none

package chtd_pkg;

   // Default limits of the table format.
   localparam int MAX_CODE_LENGTH_DEF = 16;
   localparam int MAX_SYMBOLS_DEF     = 256;

   // Field and state widths fixed by the table format.
   localparam int BYTE_W    = 8;
   localparam int BYTES_W   = 9;
   localparam int LEN_W     = 5;
   localparam int CODE_W    = 16;
   localparam int SPACE_W   = 17;
   localparam int TOTAL_W   = 9;
   localparam int POS_W     = 10;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Symbol count saturates at the largest value of its register.
   localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

   // Meaning of an input item.
   typedef enum logic [1:0] {
      ACT_START = 2'd0,
      ACT_BYTE  = 2'd1,
      ACT_BIT   = 2'd2
   } action_type;

   // Meaning of a result item.
   typedef enum logic [1:0] {
      KIND_LOADED    = 2'd0,
      KIND_SYMBOL    = 2'd1,
      KIND_INVALID   = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } kind_type;

   // One result as produced by the loader or the decoder.
   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [BYTES_W-1:0] bytes_read;
      logic [LEN_W-1:0]   code_length;
      logic               sym_ok;
   } result_type;

   // Per-length table entry seen by the decoder.
   typedef struct packed {
      logic [BYTE_W-1:0]  count;
      logic [SPACE_W-1:0] first;
      logic [TOTAL_W-1:0] base;
      logic [SPACE_W-1:0] used;
   } lookup_type;

   // Symbol memory write port.
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } store_write_type;

   // Symbol memory read port.
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] addr;
   } store_read_type;

endpackage

`default_nettype wire

// File: design/chtd_symbol_ram.sv
// Symbol memory: one write port and one registered read port.
`default_nettype none

module chtd_symbol_ram #(
   parameter int MAX_SYMBOLS = chtd_pkg::MAX_SYMBOLS_DEF
) (
   input  wire                          clock,
   input  chtd_pkg::store_write_type    wr,
   input  chtd_pkg::store_read_type     rd,
   output logic [chtd_pkg::BYTE_W-1:0]  rd_data
);
   import chtd_pkg::*;

   localparam int SymIdxW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

   logic [BYTE_W-1:0] mem [MAX_SYMBOLS];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write during table load, read during decoding; the read data is held
   // until the next enabled read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[SymIdxW-1:0]] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr[SymIdxW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/chtd_table_loader.sv
// Table loader: takes count and symbol bytes and builds the per-length first codes.
`default_nettype none

module chtd_table_loader #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF,
   parameter int MAX_SYMBOLS     = chtd_pkg::MAX_SYMBOLS_DEF,
   localparam int LenIdxW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_fire,
   input  chtd_pkg::action_type         action,
   input  wire [chtd_pkg::BYTE_W-1:0]   table_byte,
   input  wire [LenIdxW-1:0]            lookup_index,
   output chtd_pkg::lookup_type         lookup,
   output chtd_pkg::store_write_type    store_wr,
   output chtd_pkg::result_type         result,
   output logic                         table_ready
);
   import chtd_pkg::*;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_COUNTS,
      PHASE_SYMBOLS,
      PHASE_READY
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [BYTES_W-1:0]  position_ff, position_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [SPACE_W-1:0]  used_ff, used_in;

   logic [BYTE_W-1:0]   count_ff [MAX_CODE_LENGTH];
   logic [SPACE_W-1:0]  first_ff [MAX_CODE_LENGTH];
   logic [TOTAL_W-1:0]  base_ff  [MAX_CODE_LENGTH];

   logic                count_we;
   logic [LenIdxW-1:0]  count_index;
   logic                pos_in_range;
   logic [SPACE_W-1:0]  used_shift;
   logic [LEN_W-1:0]    space_shamt;
   logic [SPACE_W-1:0]  space_limit;
   logic [SPACE_W-1:0]  avail;
   logic [BYTE_W-1:0]   eff_count;
   logic [SPACE_W-1:0]  used_count;
   logic [TOTAL_W:0]    total_sum;
   logic [TOTAL_W-1:0]  total_count;
   logic [BYTES_W-1:0]  position_inc;
   logic [BYTES_W-1:0]  sym_index;
   logic                sym_last;

   // Count step: shift the code space to the next length, clip the count to
   // the space left and accumulate the symbol total.
   always_comb begin
      count_index  = position_ff[LenIdxW-1:0];
      pos_in_range = position_ff < BYTES_W'(MAX_CODE_LENGTH);
      used_shift   = (position_ff != '0) ? {used_ff[SPACE_W-2:0], 1'b0} : used_ff;
      space_shamt  = position_ff[LEN_W-1:0] + LEN_W'(1);
      space_limit  = SPACE_W'(1) << space_shamt;
      avail        = space_limit - used_shift;
      eff_count    = ({{(SPACE_W-BYTE_W){1'b0}}, table_byte} < avail) ?
                     table_byte : avail[BYTE_W-1:0];
      used_count   = used_shift + {{(SPACE_W-BYTE_W){1'b0}}, eff_count};
      total_sum    = {1'b0, total_ff} + {{(TOTAL_W+1-BYTE_W){1'b0}}, table_byte};
      total_count  = (total_sum > {1'b0, TOTAL_SAT}) ? TOTAL_SAT : total_sum[TOTAL_W-1:0];
      position_inc = position_ff + BYTES_W'(1);
      sym_index    = position_ff - BYTES_W'(MAX_CODE_LENGTH);
      sym_last     = ({1'b0, sym_index} + (BYTES_W+1)'(1)) >= {1'b0, total_ff};
   end

   // Load sequence and its results.
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      total_in    = total_ff;
      used_in     = used_ff;
      count_we    = 1'b0;
      store_wr    = '0;
      result      = '0;
      if (req_fire) begin
         case (action)
            ACT_START: begin
               phase_in    = PHASE_COUNTS;
               position_in = '0;
               total_in    = '0;
               used_in     = '0;
            end
            ACT_BYTE: begin
               if (phase_ff == PHASE_COUNTS && pos_in_range) begin
                  count_we    = 1'b1;
                  used_in     = used_count;
                  total_in    = total_count;
                  position_in = position_inc;
                  if (position_inc == BYTES_W'(MAX_CODE_LENGTH)) begin
                     result.bytes_read = position_inc;
                     if (total_count >= TOTAL_W'(MAX_SYMBOLS)) begin
                        phase_in     = PHASE_IDLE;
                        result.valid = 1'b1;
                        result.kind  = KIND_TOO_LARGE;
                     end else if (total_count == '0) begin
                        phase_in     = PHASE_READY;
                        result.valid = 1'b1;
                        result.kind  = KIND_LOADED;
                     end else begin
                        phase_in = PHASE_SYMBOLS;
                     end
                  end
               end else if (phase_ff == PHASE_SYMBOLS) begin
                  store_wr.en   = sym_index < BYTES_W'(MAX_SYMBOLS);
                  store_wr.addr = sym_index[BYTE_W-1:0];
                  store_wr.data = table_byte;
                  position_in   = position_inc;
                  if (sym_last) begin
                     phase_in          = PHASE_READY;
                     result.valid      = 1'b1;
                     result.kind       = KIND_LOADED;
                     result.bytes_read = position_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Load state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         position_ff <= '0;
         total_ff    <= '0;
         used_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         total_ff    <= total_in;
         used_ff     <= used_in;
      end
   end

   // Per-length table: clipped count, first code and base symbol index.
   always_ff @(posedge clock) begin
      if (count_we) begin
         count_ff[count_index] <= eff_count;
         first_ff[count_index] <= used_shift;
         base_ff[count_index]  <= total_ff;
      end
   end

   always_comb begin
      lookup.count = count_ff[lookup_index];
      lookup.first = first_ff[lookup_index];
      lookup.base  = base_ff[lookup_index];
      lookup.used  = used_ff;
   end

   assign table_ready = (phase_ff == PHASE_READY);

endmodule

`default_nettype wire

// File: design/chtd_bit_decoder.sv
// Bit decoder: extends the current code by one bit and matches it per length.
`default_nettype none

module chtd_bit_decoder #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF,
   parameter int MAX_SYMBOLS     = chtd_pkg::MAX_SYMBOLS_DEF,
   localparam int LenIdxW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_fire,
   input  chtd_pkg::action_type       action,
   input  wire                        code_bit,
   input  wire                        table_ready,
   input  chtd_pkg::lookup_type       lookup,
   output logic [LenIdxW-1:0]         lookup_index,
   output chtd_pkg::store_read_type   store_rd,
   output chtd_pkg::result_type       result
);
   import chtd_pkg::*;

   logic [CODE_W-1:0]  code_ff, code_in;
   logic [LEN_W-1:0]   length_ff, length_in;

   logic [CODE_W-1:0]  code_next;
   logic [LEN_W-1:0]   length_next;
   logic               too_long;
   logic [SPACE_W-1:0] code_ext;
   logic [SPACE_W-1:0] diff;
   logic               hit;
   logic [POS_W-1:0]   pos;
   logic               pos_ok;
   logic [LEN_W-1:0]   prefix_shamt;
   logic [SPACE_W-1:0] prefix;
   logic               out_of_space;

   // The table entry for the new length sits at the old length.
   assign lookup_index = length_ff[LenIdxW-1:0];

   // Match against the codes of this length and test the left-aligned prefix
   // against the used code space.
   always_comb begin
      code_next    = {code_ff[CODE_W-2:0], code_bit};
      length_next  = length_ff + LEN_W'(1);
      too_long     = length_next > LEN_W'(MAX_CODE_LENGTH);
      code_ext     = {1'b0, code_next};
      diff         = code_ext - lookup.first;
      hit          = (code_ext >= lookup.first) &&
                     (diff < {{(SPACE_W-BYTE_W){1'b0}}, lookup.count});
      pos          = {1'b0, lookup.base} + {{(POS_W-BYTE_W){1'b0}}, diff[BYTE_W-1:0]};
      pos_ok       = pos < POS_W'(MAX_SYMBOLS);
      prefix_shamt = LEN_W'(MAX_CODE_LENGTH) - length_next;
      prefix       = code_ext << prefix_shamt;
      out_of_space = prefix >= lookup.used;
   end

   // Code register update and result.
   always_comb begin
      code_in       = code_ff;
      length_in     = length_ff;
      result        = '0;
      store_rd.en   = 1'b0;
      store_rd.addr = pos[BYTE_W-1:0];
      if (req_fire) begin
         case (action)
            ACT_START: begin
               code_in   = '0;
               length_in = '0;
            end
            ACT_BIT: begin
               if (table_ready) begin
                  result.code_length = length_next;
                  if (too_long) begin
                     code_in      = '0;
                     length_in    = '0;
                     result.valid = 1'b1;
                     result.kind  = KIND_INVALID;
                  end else if (hit) begin
                     code_in       = '0;
                     length_in     = '0;
                     result.valid  = 1'b1;
                     result.kind   = KIND_SYMBOL;
                     result.sym_ok = pos_ok;
                     store_rd.en   = pos_ok;
                  end else if (out_of_space) begin
                     code_in      = '0;
                     length_in    = '0;
                     result.valid = 1'b1;
                     result.kind  = KIND_INVALID;
                  end else begin
                     code_in   = code_next;
                     length_in = length_next;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff   <= '0;
         length_ff <= '0;
      end else begin
         code_ff   <= code_in;
         length_ff <= length_in;
      end
   end

endmodule

`default_nettype wire

// File: design/canonical_huffman_table_decoder.sv
// Top level of the canonical Huffman table decoder with its result register.
//
//   Channel  Direction  tuser          tdata
//   req_     in         action[1:0]    table_byte[7:0], code_bit[8]
//   rsp_     out        kind[1:0]      symbol[7:0], bytes_read[16:8], code_length[21:17]
//
// One input item is taken per cycle while no held result blocks req_; its result, if any, is shown in the cycle after.
// Table state and the code register update at the accepting edge; the symbol
// memory read is registered into the result stage.
// Reset clears the load state and code register; the stores need no clearing pass.
// A result held by a low rsp_tready blocks the next transfer on req_.
`default_nettype none

module canonical_huffman_table_decoder #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF,
   parameter int MAX_SYMBOLS     = chtd_pkg::MAX_SYMBOLS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [chtd_pkg::REQ_DATA_W-1:0]    req_tdata,  // table_byte[7:0], code_bit[8]
   input  wire [1:0]                         req_tuser,  // action[1:0]
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [chtd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // symbol, bytes_read, code_length
   output logic [1:0]                        rsp_tuser   // kind[1:0]
);
   import chtd_pkg::*;

   localparam int LenIdxW = (MAX_CODE_LENGTH > 1) ? $clog2(MAX_CODE_LENGTH) : 1;

   logic               req_fire;
   action_type         action;
   logic [BYTE_W-1:0]  table_byte;
   logic               code_bit;

   logic [LenIdxW-1:0] lookup_index;
   lookup_type         lookup;
   store_write_type    store_wr;
   store_read_type     store_rd;
   result_type         load_result;
   result_type         dec_result;
   result_type         result;
   logic               table_ready;
   logic [BYTE_W-1:0]  rd_data;

   logic               rsp_valid_ff;
   result_type         rsp_ff;
   logic [BYTE_W-1:0]  rsp_symbol;

   // Input transfer and field unpacking.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign action     = action_type'(req_tuser);
   assign table_byte = req_tdata[BYTE_W-1:0];
   assign code_bit   = req_tdata[BYTE_W];

   chtd_table_loader #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .MAX_SYMBOLS     (MAX_SYMBOLS)
   ) u_loader (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .action       (action),
      .table_byte   (table_byte),
      .lookup_index (lookup_index),
      .lookup       (lookup),
      .store_wr     (store_wr),
      .result       (load_result),
      .table_ready  (table_ready)
   );

   chtd_bit_decoder #(
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
      .MAX_SYMBOLS     (MAX_SYMBOLS)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .action       (action),
      .code_bit     (code_bit),
      .table_ready  (table_ready),
      .lookup       (lookup),
      .lookup_index (lookup_index),
      .store_rd     (store_rd),
      .result       (dec_result)
   );

   chtd_symbol_ram #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_symbol_ram (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (rd_data)
   );

   // At most one of the two units reports for a given item.
   always_comb begin
      case (action)
         ACT_BYTE: result = load_result;
         ACT_BIT:  result = dec_result;
         default:  result = '0;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= result;
      end
   end

   // Result packing.
   assign rsp_symbol = rsp_ff.sym_ok ? rd_data : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {{(RSP_DATA_W-BYTE_W-BYTES_W-LEN_W){1'b0}},
                        rsp_ff.code_length, rsp_ff.bytes_read, rsp_symbol};

endmodule

`default_nettype wire

// File: design/chtd_checker.sv
// Port checker for the canonical Huffman table decoder, bound to the top level.
`default_nettype none

module chtd_checker #(
   parameter int MAX_CODE_LENGTH = chtd_pkg::MAX_CODE_LENGTH_DEF
) (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [chtd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire [1:0]                        rsp_tuser
);
   import chtd_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The input side is never blocked while no result is pending.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with an empty result register");

   // A new result appears only after an input transfer.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an input transfer");

   // A decoded symbol carries a code length and no byte count.
   a_sym_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SYMBOL |->
         rsp_tdata[16:8] == '0 && rsp_tdata[21:17] != '0 &&
         rsp_tdata[21:17] <= LEN_W'(MAX_CODE_LENGTH))
      else $error("bad fields on a decoded symbol");

   // A rejected table reports exactly the count bytes.
   a_too_large: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TOO_LARGE |->
         rsp_tdata[16:8] == BYTES_W'(MAX_CODE_LENGTH) && rsp_tdata[7:0] == '0 &&
         rsp_tdata[21:17] == '0)
      else $error("bad fields on a rejected table");

endmodule

bind canonical_huffman_table_decoder chtd_checker #(
   .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
) u_chtd_checker (.*);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the canonical Huffman table decoder.
`default_nettype none

module tb;
   import chtd_pkg::*;

   // Unassigned action code; the block must ignore it.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam int ITEM_TARGET  = 1250;
   localparam int QUIET_ITEMS  = 150;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 3000;
   localparam int PRINT_LIMIT  = 40;

   // Load phases of the predicted decoder.
   typedef enum logic [1:0] {
      LD_IDLE    = 2'd0,
      LD_COUNTS  = 2'd1,
      LD_SYMBOLS = 2'd2,
      LD_READY   = 2'd3
   } load_phase_type;

   // Table shapes that the stimulus generator can build.
   typedef enum int {
      SHAPE_SPREAD,
      SHAPE_CHAIN,
      SHAPE_OVERFULL,
      SHAPE_HUGE,
      SHAPE_EMPTY,
      SHAPE_WIDE
   } table_shape_type;

   typedef struct {
      logic [1:0] act;
      logic [7:0] tbyte;
      logic       cbit;
      bit         drain;
   } req_item_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  symbol;
      logic [BYTES_W-1:0] nbytes;
      logic [LEN_W-1:0]   clen;
   } decode_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // table_byte[7:0], code_bit[8]
   logic [1:0]            req_tuser  = '0;  // action[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // symbol[7:0], bytes_read[16:8], code_length[21:17]
   logic [1:0]            rsp_tuser;        // kind[1:0]

   canonical_huffman_table_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   req_item_type      code_items[$];
   decode_result_type predicted_outputs[$];
   int             total_items    = 0;
   int             accepted_items = 0;
   int             results_seen   = 0;
   int             error_count    = 0;
   int             idle_cycles    = 0;
   logic           req_fire       = 1'b0;
   bit             quiet          = 1'b0;

   // Predicted decoder state.
   logic [7:0]         tbl_count [16];
   logic [SPACE_W-1:0] tbl_first [16];
   logic [TOTAL_W-1:0] tbl_base  [16];
   logic [7:0]         sym_mem   [256];
   load_phase_type     ld_phase   = LD_IDLE;
   logic [8:0]         ld_pos     = '0;
   logic [TOTAL_W-1:0] sym_total  = '0;
   logic [SPACE_W-1:0] space_used = '0;
   logic [CODE_W-1:0]  code_reg   = '0;
   logic [LEN_W-1:0]   code_len   = '0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the predicted decoder by one accepted item; returns 1 when a result is due.
   function automatic bit decode_step(input logic [1:0] act, input logic [7:0] tb,
                                      input logic cb, output decode_result_type r);
      int unsigned idx, avail, eff, sum, code, first, len, pos;
      r = '0;
      decode_step = 1'b0;
      case (act)
         ACT_START: begin
            ld_phase   = LD_COUNTS;
            ld_pos     = '0;
            sym_total  = '0;
            space_used = '0;
            code_reg   = '0;
            code_len   = '0;
         end
         ACT_BYTE: begin
            if (ld_phase == LD_COUNTS) begin
               // Count byte: the first code of this length follows the previous length.
               idx = 32'(ld_pos);
               if (idx > 0) space_used = space_used << 1;
               tbl_first[idx] = space_used;
               tbl_base[idx]  = sym_total;
               avail = (32'd1 << (idx + 1)) - 32'(space_used);
               eff   = (32'(tb) < avail) ? 32'(tb) : avail;
               tbl_count[idx] = eff[7:0];
               space_used = space_used + SPACE_W'(eff);
               sum = 32'(sym_total) + 32'(tb);
               sym_total = (sum > 511) ? 9'd511 : sum[8:0];
               ld_pos = 9'(idx + 1);
               if (ld_pos == 16) begin
                  if (sym_total >= 256) begin
                     ld_phase = LD_IDLE;
                     r.kind = KIND_TOO_LARGE;
                     r.nbytes = ld_pos;
                     decode_step = 1'b1;
                  end else if (sym_total == 0) begin
                     ld_phase = LD_READY;
                     r.kind = KIND_LOADED;
                     r.nbytes = ld_pos;
                     decode_step = 1'b1;
                  end else begin
                     ld_phase = LD_SYMBOLS;
                  end
               end
            end else if (ld_phase == LD_SYMBOLS) begin
               idx = 32'(ld_pos) - 16;
               if (idx < 256) sym_mem[idx] = tb;
               ld_pos = ld_pos + 9'd1;
               if (idx + 1 >= 32'(sym_total)) begin
                  ld_phase = LD_READY;
                  r.kind = KIND_LOADED;
                  r.nbytes = ld_pos;
                  decode_step = 1'b1;
               end
            end
         end
         ACT_BIT: begin
            if (ld_phase == LD_READY) begin
               code_reg = {code_reg[CODE_W-2:0], cb};
               code_len = code_len + 5'd1;
               len  = 32'(code_len);
               code = 32'(code_reg);
               if (len < 1 || len > 16) begin
                  r.kind = KIND_INVALID;
                  r.clen = len[4:0];
                  code_reg = '0;
                  code_len = '0;
                  decode_step = 1'b1;
               end else begin
                  first = 32'(tbl_first[len-1]);
                  if (code >= first && code - first < 32'(tbl_count[len-1])) begin
                     // The code falls among the codes of its length.
                     pos = 32'(tbl_base[len-1]) + (code - first);
                     r.kind = KIND_SYMBOL;
                     r.symbol = (pos < 256) ? sym_mem[pos] : '0;
                     r.clen = len[4:0];
                     code_reg = '0;
                     code_len = '0;
                     decode_step = 1'b1;
                  end else if ((code << (16 - len)) >= 32'(space_used)) begin
                     // The prefix has left the used code space.
                     r.kind = KIND_INVALID;
                     r.clen = len[4:0];
                     code_reg = '0;
                     code_len = '0;
                     decode_step = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR: %s got %0d expected %0d at result %0d", what, got, want,
                  results_seen);
   endtask

   task automatic add_item(input logic [1:0] act, input logic [7:0] tb, input logic cb,
                           input bit drain);
      req_item_type it;
      it.act   = act;
      it.tbyte = tb;
      it.cbit  = cb;
      it.drain = drain;
      code_items.push_back(it);
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_item(ACT_BYTE, b, 1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic add_bit(input logic x);
      add_item(ACT_BIT, 8'($urandom_range(0, 255)), x, 1'b0);
   endtask

   // Items that a loading or idle block must ignore.
   task automatic add_load_noise();
      if ($urandom_range(0, 1) == 0)
         add_bit(1'($urandom_range(0, 1)));
      else
         add_item(ACT_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // Items that a decoding block must ignore.
   task automatic add_decode_noise();
      if ($urandom_range(0, 1) == 0)
         add_byte(8'($urandom_range(0, 255)));
      else
         add_item(ACT_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // One table load, possibly cut short, followed by a stretch of code bits when the table is complete and fits.
   task automatic send_table(input table_shape_type shape, input bit drain);
      logic [7:0] counts [16];
      int used, avail, c, remaining, deep_len, sum, nbytes, cut, nbits, k;
      foreach (counts[i]) counts[i] = '0;
      add_item(ACT_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), drain);

      // Build the counts per length.
      case (shape)
         SHAPE_SPREAD: begin
            remaining = $urandom_range(1, 14);
            deep_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(1, 8);
            used = 0;
            for (int l = 0; l < 16; l++) begin
               if (l > 0) used = used * 2;
               avail = (1 << (l + 1)) - used;
               c = (avail < remaining) ? avail : remaining;
               if (l + 1 < deep_len) c = $urandom_range(0, (c < 3) ? c : 3);
               else if (l + 1 > deep_len) c = 0;
               counts[l] = c[7:0];
               used += c;
               remaining -= c;
            end
         end
         SHAPE_CHAIN: begin
            for (int l = 0; l < 15; l++) counts[l] = 8'd1;
            counts[15] = 8'($urandom_range(1, 2));
         end
         SHAPE_OVERFULL: begin
            counts[0] = 8'($urandom_range(3, 6));
            counts[1] = 8'($urandom_range(0, 3));
            counts[$urandom_range(2, 15)] = 8'($urandom_range(0, 4));
         end
         SHAPE_HUGE: begin
            foreach (counts[i]) counts[i] = 8'($urandom_range(0, 3));
            counts[7] = 8'd255;
            counts[$urandom_range(8, 15)] = 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 0) counts[$urandom_range(0, 6)] = 8'd255;
         end
         SHAPE_WIDE: counts[7] = 8'd255;
         default: ;
      endcase

      sum = 0;
      foreach (counts[i]) sum += 32'(counts[i]);
      nbytes = 16 + ((sum < 256) ? sum : 0);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, nbytes - 1) : nbytes;

      for (int i = 0; i < cut; i++) begin
         if (i < 16) begin
            add_byte(counts[i]);
         end else begin
            case ($urandom_range(0, 7))
               0:       add_byte(8'd0);
               1:       add_byte(8'd255);
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end
         if ($urandom_range(0, 19) == 0) add_load_noise();
      end

      if (cut < nbytes || sum >= 256) begin
         // No table is ready: everything but a start is ignored until the next load.
         repeat ($urandom_range(1, 3)) add_load_noise();
      end else begin
         nbits = (shape == SHAPE_WIDE) ? 400 : $urandom_range(10, 70);
         while (nbits > 0) begin
            if (shape == SHAPE_CHAIN) begin
               // A run of ones selects the code length; a closing zero ends the code, a closing one extends the run.
               k = $urandom_range(0, 15);
               repeat (k) add_bit(1'b1);
               add_bit(1'($urandom_range(0, 1)));
               nbits -= k + 1;
            end else begin
               add_bit(1'($urandom_range(0, 1)));
               nbits--;
            end
            if ($urandom_range(0, 14) == 0) add_decode_noise();
         end
      end
   endtask

   // Sender: presents the queued items, with random gaps and the drain pauses.
   int req_gap = 0;
   always @(negedge clock) begin
      req_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (code_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && code_items[0].drain && predicted_outputs.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else begin
            it = code_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'({it.cbit, it.tbyte});
            req_tuser  <= it.act;
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs once results have started to flow.
   int rsp_stall = 0;
   int rsp_hold  = 0;
   int next_hold = 40;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!quiet && next_hold <= 120 && results_seen >= next_hold) begin
         next_hold += 80;
         rsp_hold = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: checks each result transfer, predicts each input transfer, and watches for hangs.
   always @(posedge clock) begin
      decode_result_type want, got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;

         if (rsp_tvalid && rsp_tready) begin
            got.kind   = kind_type'(rsp_tuser);
            got.symbol = rsp_tdata[7:0];
            got.nbytes = rsp_tdata[16:8];
            got.clen   = rsp_tdata[21:17];
            if (predicted_outputs.size() == 0) begin
               report_mismatch("unexpected result, kind", got.kind, -1);
            end else begin
               want = predicted_outputs.pop_front();
               if (got.kind != want.kind)
                  report_mismatch("kind", got.kind, want.kind);
               if (got.symbol != want.symbol)
                  report_mismatch("symbol", got.symbol, want.symbol);
               if (got.nbytes != want.nbytes)
                  report_mismatch("bytes_read", got.nbytes, want.nbytes);
               if (got.clen != want.clen)
                  report_mismatch("code_length", got.clen, want.clen);
            end
            results_seen++;
         end

         if (req_tvalid && req_tready) begin
            if (decode_step(req_tuser, req_tdata[7:0], req_tdata[8], want))
               predicted_outputs.push_back(want);
            accepted_items++;
            quiet = (accepted_items >= total_items - QUIET_ITEMS);
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      // Directed opening: ignored items with no table, then an empty table.
      add_bit(1'b1);
      add_byte(8'd255);
      add_item(ACT_SPARE, 8'd0, 1'b0, 1'b0);
      add_item(ACT_START, 8'd0, 1'b0, 1'b0);
      repeat (16) add_byte(8'd0);
      add_bit(1'b1);
      add_bit(1'b0);
      add_byte(8'h5A);
      add_item(ACT_SPARE, 8'hFF, 1'b1, 1'b0);

      // Widest legal table, an oversized one, the deepest codes, an overfull one, then random tables.
      send_table(SHAPE_WIDE, 1'b1);
      send_table(SHAPE_HUGE, 1'b1);
      send_table(SHAPE_CHAIN, 1'b0);
      send_table(SHAPE_OVERFULL, 1'b0);
      while (code_items.size() < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            6:       send_table(SHAPE_CHAIN, $urandom_range(0, 4) == 0);
            7:       send_table(SHAPE_OVERFULL, $urandom_range(0, 4) == 0);
            8:       send_table(SHAPE_HUGE, $urandom_range(0, 4) == 0);
            9:       send_table(SHAPE_EMPTY, $urandom_range(0, 4) == 0);
            default: send_table(SHAPE_SPREAD, $urandom_range(0, 4) == 0);
         endcase
      end
      total_items = code_items.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and every result to arrive, then let the pipe settle.
      while (accepted_items != total_items || predicted_outputs.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (error_count == 0 && predicted_outputs.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
